>>> hw/rtl/dlrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlrg_pkg;

  typedef enum logic [3:0] {
    FN_INIT          = 4'd0,
    FN_CREATED       = 4'd1,
    FN_PREPARE       = 4'd2,
    FN_ENTER_ACTIVE  = 4'd3,
    FN_ACQUIRE       = 4'd4,
    FN_RELEASE       = 4'd5,
    FN_BEGIN_RUNDOWN = 4'd6,
    FN_COMPLETE_EXIT = 4'd7,
    FN_RELEASE_HW    = 4'd8
  } func_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_PHASE      = 4'd1,
    ST_EXHAUSTED  = 4'd2,
    ST_BADID      = 4'd3,
    ST_CLOSED     = 4'd4,
    ST_STALE      = 4'd5,
    ST_OVERFLOW   = 4'd6,
    ST_NONE       = 4'd7,
    ST_INCOMPLETE = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    PH_UNSET    = 3'd0,
    PH_CREATED  = 3'd1,
    PH_PREPARED = 3'd2,
    PH_ACTIVE   = 3'd3,
    PH_RUNDOWN  = 3'd4,
    PH_STOPPED  = 3'd5,
    PH_RELEASED = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_EVAL = 2'd1,
    CS_OUT  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/device_lifecycle_rundown_gate_core.sv
// Device lifecycle rundown gate.
// Input channel: in_valid / in_stall carry one lifecycle event (in_func and
// in_generation_in). Result channel: out_valid / out_stall carry one result
// per event: the status code and a full snapshot of phase, current and next
// generation, outstanding count and admission flag after the event.
// An item is taken at a clock edge with valid high and stall low.
// The result is registered: an accepted event goes from the idle state
// through the evaluate state, where the new state is committed, to the
// output state, where out_valid stays high until the result is taken.
// The controller holds one event at a time through accept, evaluate and
// deliver steps, so no new event is taken before the result is delivered.
// Reset (rst_n low, synchronous): phase unset, current generation 0, next
// generation 1, count 0, admission closed; no result pending.
// While out_stall is high the result holds steady and in_stall stays high,
// so no further event is taken until the result is delivered.
`timescale 1ns / 1ps
`default_nettype none

module device_lifecycle_rundown_gate_core #(
  parameter int GEN_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_func,
  input  wire logic [31:0] in_generation_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_status,
  output logic [2:0]       out_phase_out,
  output logic [31:0]      out_current_gen_out,
  output logic [31:0]      out_next_gen_out,
  output logic [15:0]      out_outstanding_out,
  output logic             out_admission_out
);
  import dlrg_pkg::*;

  dp_cmd_t cmd;

  dlrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  dlrg_datapath #(
    .GEN_BITS   (GEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_func             (in_func),
    .in_generation_in    (in_generation_in),
    .out_status          (out_status),
    .out_phase_out       (out_phase_out),
    .out_current_gen_out (out_current_gen_out),
    .out_next_gen_out    (out_next_gen_out),
    .out_outstanding_out (out_outstanding_out),
    .out_admission_out   (out_admission_out)
  );

endmodule

`default_nettype wire

>>> hw/rtl/dlrg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dlrg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dlrg_pkg::dp_cmd_t      cmd
);
  import dlrg_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_EVAL;
      end
      CS_EVAL: begin
        state_nxt = CS_OUT;
      end
      CS_OUT: begin
        if (!out_stall) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      CS_EVAL: begin
        cmd.commit = 1'b1;
      end
      CS_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/dlrg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dlrg_datapath #(
  parameter int GEN_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dlrg_pkg::dp_cmd_t cmd,
  input  wire logic [3:0]        in_func,
  input  wire logic [31:0]       in_generation_in,
  output logic [3:0]             out_status,
  output logic [2:0]             out_phase_out,
  output logic [31:0]            out_current_gen_out,
  output logic [31:0]            out_next_gen_out,
  output logic [15:0]            out_outstanding_out,
  output logic                   out_admission_out
);
  import dlrg_pkg::*;

  localparam int GW = (GEN_BITS > 32) ? GEN_BITS : 32;
  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [3:0]            func_r;
  logic [GEN_BITS-1:0]   gen_r;
  status_t               status_r;
  phase_t                phase_r;
  logic [GEN_BITS-1:0]   cur_r;
  logic [GEN_BITS-1:0]   nxt_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  adm_r;

  status_t               status_nxt;
  phase_t                phase_nxt;
  logic [GEN_BITS-1:0]   cur_nxt;
  logic [GEN_BITS-1:0]   nxt_nxt;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                  adm_nxt;

  logic [GW-1:0] gen_in_w;
  logic [GW-1:0] cur_w;
  logic [GW-1:0] nxt_w;
  logic [CW-1:0] cnt_w;

  logic gen_zero;
  logic gen_match;

  assign gen_in_w = GW'(in_generation_in);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      gen_r  <= gen_in_w[GEN_BITS-1:0];
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_UNSET;
      cur_r   <= '0;
      nxt_r   <= GEN_BITS'(1);
      cnt_r   <= '0;
      adm_r   <= 1'b0;
    end else if (cmd.commit) begin
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      nxt_r   <= nxt_nxt;
      cnt_r   <= cnt_nxt;
      adm_r   <= adm_nxt;
    end
  end

  assign gen_zero  = (gen_r == '0);
  assign gen_match = (gen_r == cur_r);

  always_comb begin
    status_nxt = ST_OK;
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    nxt_nxt    = nxt_r;
    cnt_nxt    = cnt_r;
    adm_nxt    = adm_r;
    unique case (func_r)
      FN_INIT: begin
        phase_nxt = PH_UNSET;
        cur_nxt   = '0;
        nxt_nxt   = GEN_BITS'(1);
        cnt_nxt   = '0;
        adm_nxt   = 1'b0;
      end
      FN_CREATED: begin
        if (phase_r != PH_UNSET) status_nxt = ST_PHASE;
        else phase_nxt = PH_CREATED;
      end
      FN_PREPARE: begin
        if (phase_r != PH_CREATED) begin
          status_nxt = ST_PHASE;
        end else begin
          phase_nxt = PH_PREPARED;
          cur_nxt   = '0;
          cnt_nxt   = '0;
          adm_nxt   = 1'b0;
        end
      end
      FN_ENTER_ACTIVE: begin
        if (phase_r != PH_PREPARED && phase_r != PH_STOPPED) begin
          status_nxt = ST_PHASE;
        end else if (nxt_r == '0 || nxt_r == '1) begin
          status_nxt = ST_EXHAUSTED;
        end else begin
          cur_nxt   = nxt_r;
          nxt_nxt   = nxt_r + GEN_BITS'(1);
          cnt_nxt   = '0;
          adm_nxt   = 1'b1;
          phase_nxt = PH_ACTIVE;
        end
      end
      FN_ACQUIRE: begin
        priority if (gen_zero)        status_nxt = ST_BADID;
        else if (phase_r != PH_ACTIVE) status_nxt = ST_PHASE;
        else if (!adm_r)              status_nxt = ST_CLOSED;
        else if (!gen_match)          status_nxt = ST_STALE;
        else if (cnt_r == '1)         status_nxt = ST_OVERFLOW;
        else                          cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
      FN_RELEASE: begin
        priority if (gen_zero) status_nxt = ST_BADID;
        else if (!gen_match)   status_nxt = ST_STALE;
        else if (phase_r != PH_ACTIVE && phase_r != PH_RUNDOWN) status_nxt = ST_PHASE;
        else if (cnt_r == '0)  status_nxt = ST_NONE;
        else                   cnt_nxt = cnt_r - COUNT_BITS'(1);
      end
      FN_BEGIN_RUNDOWN: begin
        priority if (gen_zero)         status_nxt = ST_BADID;
        else if (phase_r != PH_ACTIVE) status_nxt = ST_PHASE;
        else if (!gen_match)           status_nxt = ST_STALE;
        else begin
          adm_nxt   = 1'b0;
          phase_nxt = PH_RUNDOWN;
        end
      end
      FN_COMPLETE_EXIT: begin
        priority if (gen_zero)          status_nxt = ST_BADID;
        else if (!gen_match)            status_nxt = ST_STALE;
        else if (phase_r != PH_RUNDOWN) status_nxt = ST_PHASE;
        else if (cnt_r != '0)           status_nxt = ST_INCOMPLETE;
        else begin
          phase_nxt = PH_STOPPED;
          cur_nxt   = '0;
          adm_nxt   = 1'b0;
        end
      end
      FN_RELEASE_HW: begin
        if ((phase_r != PH_PREPARED && phase_r != PH_STOPPED) ||
            cur_r != '0 || adm_r || cnt_r != '0) begin
          status_nxt = ST_PHASE;
        end else begin
          phase_nxt = PH_RELEASED;
        end
      end
      default: status_nxt = ST_PHASE;
    endcase
  end

  assign cur_w = GW'(cur_r);
  assign nxt_w = GW'(nxt_r);
  assign cnt_w = CW'(cnt_r);

  assign out_status          = status_r;
  assign out_phase_out       = phase_r;
  assign out_current_gen_out = cur_w[31:0];
  assign out_next_gen_out    = nxt_w[31:0];
  assign out_outstanding_out = cnt_w[15:0];
  assign out_admission_out   = adm_r;

endmodule

`default_nettype wire

>>> sim/device_lifecycle_rundown_gate_core_tb.sv
`timescale 1ns / 1ps

module device_lifecycle_rundown_gate_core_tb;
  import dlrg_pkg::*;

  localparam logic [3:0]  FN_UNDEFINED = 4'd15;
  localparam logic [31:0] GEN_LIMIT    = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_LIMIT  = 16'hFFFF;
  localparam int          RANDOM_ITEMS = 850;

  typedef struct packed {
    status_t     status;
    phase_t      phase;
    logic [31:0] cur_gen;
    logic [31:0] nxt_gen;
    logic [15:0] ops;
    logic        admit;
  } snapshot_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] gen;
    logic        typed_exp;
    snapshot_t   want;
  } event_row_t;

  localparam snapshot_t NO_SNAP = '0;

  localparam event_row_t LIFECYCLE_TABLE [0:24] = '{
    '{FN_RELEASE_HW,    32'd0,        1'b1, '{ST_PHASE, PH_UNSET, 32'd0, 32'd1, 16'd0, 1'b0}},
    '{FN_ACQUIRE,       32'd0,        1'b1, '{ST_BADID, PH_UNSET, 32'd0, 32'd1, 16'd0, 1'b0}},
    '{FN_ACQUIRE,       32'd5,        1'b1, '{ST_PHASE, PH_UNSET, 32'd0, 32'd1, 16'd0, 1'b0}},
    '{FN_UNDEFINED,     GEN_LIMIT,    1'b1, '{ST_PHASE, PH_UNSET, 32'd0, 32'd1, 16'd0, 1'b0}},
    '{FN_ENTER_ACTIVE,  32'd0,        1'b1, '{ST_PHASE, PH_UNSET, 32'd0, 32'd1, 16'd0, 1'b0}},
    '{FN_CREATED,       GEN_LIMIT,    1'b1, '{ST_OK, PH_CREATED, 32'd0, 32'd1, 16'd0, 1'b0}},
    '{FN_CREATED,       32'd0,        1'b0, NO_SNAP},
    '{FN_PREPARE,       32'd0,        1'b0, NO_SNAP},
    '{FN_RELEASE_HW,    32'd0,        1'b0, NO_SNAP},
    '{FN_INIT,          GEN_LIMIT,    1'b1, '{ST_OK, PH_UNSET, 32'd0, 32'd1, 16'd0, 1'b0}},
    '{FN_CREATED,       32'd0,        1'b0, NO_SNAP},
    '{FN_PREPARE,       32'd0,        1'b0, NO_SNAP},
    '{FN_ENTER_ACTIVE,  32'd0,        1'b1, '{ST_OK, PH_ACTIVE, 32'd1, 32'd2, 16'd0, 1'b1}},
    '{FN_ACQUIRE,       32'd2,        1'b1, '{ST_STALE, PH_ACTIVE, 32'd1, 32'd2, 16'd0, 1'b1}},
    '{FN_ACQUIRE,       32'd1,        1'b0, NO_SNAP},
    '{FN_RELEASE,       GEN_LIMIT,    1'b1, '{ST_STALE, PH_ACTIVE, 32'd1, 32'd2, 16'd1, 1'b1}},
    '{FN_COMPLETE_EXIT, 32'd1,        1'b0, NO_SNAP},
    '{FN_BEGIN_RUNDOWN, 32'd1,        1'b0, NO_SNAP},
    '{FN_ACQUIRE,       32'd1,        1'b0, NO_SNAP},
    '{FN_COMPLETE_EXIT, 32'd1,        1'b1,
      '{ST_INCOMPLETE, PH_RUNDOWN, 32'd1, 32'd2, 16'd1, 1'b0}},
    '{FN_RELEASE,       32'd1,        1'b0, NO_SNAP},
    '{FN_RELEASE,       32'd1,        1'b1, '{ST_NONE, PH_RUNDOWN, 32'd1, 32'd2, 16'd0, 1'b0}},
    '{FN_COMPLETE_EXIT, 32'd1,        1'b0, NO_SNAP},
    '{FN_ENTER_ACTIVE,  32'd0,        1'b0, NO_SNAP},
    '{FN_BEGIN_RUNDOWN, 32'd0,        1'b1, '{ST_BADID, PH_ACTIVE, 32'd2, 32'd3, 16'd0, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_func = FN_INIT;
  logic [31:0] in_generation_in = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [2:0]  out_phase_out;
  logic [31:0] out_current_gen_out;
  logic [31:0] out_next_gen_out;
  logic [15:0] out_outstanding_out;
  logic        out_admission_out;

  phase_t      lc_phase;
  logic [31:0] lc_cur_gen;
  logic [31:0] lc_next_gen;
  logic [15:0] lc_ops;
  logic        lc_admit;

  snapshot_t   snapshot_q[$];
  snapshot_t   head;
  int          n_items = 0;
  int          n_errors = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  device_lifecycle_rundown_gate_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_generation_in    (in_generation_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_phase_out       (out_phase_out),
    .out_current_gen_out (out_current_gen_out),
    .out_next_gen_out    (out_next_gen_out),
    .out_outstanding_out (out_outstanding_out),
    .out_admission_out   (out_admission_out)
  );

  always #10 clk = ~clk;

  function automatic void clear_lifecycle();
    lc_phase    = PH_UNSET;
    lc_cur_gen  = 32'd0;
    lc_next_gen = 32'd1;
    lc_ops      = 16'd0;
    lc_admit    = 1'b0;
  endfunction

  function automatic snapshot_t apply_event(logic [3:0] f, logic [31:0] g);
    status_t st;
    st = ST_OK;
    case (f)
      FN_INIT: clear_lifecycle();
      FN_CREATED: begin
        if (lc_phase != PH_UNSET) st = ST_PHASE;
        else lc_phase = PH_CREATED;
      end
      FN_PREPARE: begin
        if (lc_phase != PH_CREATED) st = ST_PHASE;
        else begin
          lc_phase   = PH_PREPARED;
          lc_cur_gen = 32'd0;
          lc_ops     = 16'd0;
          lc_admit   = 1'b0;
        end
      end
      FN_ENTER_ACTIVE: begin
        if (lc_phase != PH_PREPARED && lc_phase != PH_STOPPED) st = ST_PHASE;
        else if (lc_next_gen == 32'd0 || lc_next_gen == GEN_LIMIT) st = ST_EXHAUSTED;
        else begin
          lc_cur_gen  = lc_next_gen;
          lc_next_gen = lc_next_gen + 32'd1;
          lc_ops      = 16'd0;
          lc_admit    = 1'b1;
          lc_phase    = PH_ACTIVE;
        end
      end
      FN_ACQUIRE: begin
        if (g == 32'd0) st = ST_BADID;
        else if (lc_phase != PH_ACTIVE) st = ST_PHASE;
        else if (!lc_admit) st = ST_CLOSED;
        else if (g != lc_cur_gen) st = ST_STALE;
        else if (lc_ops == COUNT_LIMIT) st = ST_OVERFLOW;
        else lc_ops = lc_ops + 16'd1;
      end
      FN_RELEASE: begin
        if (g == 32'd0) st = ST_BADID;
        else if (g != lc_cur_gen) st = ST_STALE;
        else if (lc_phase != PH_ACTIVE && lc_phase != PH_RUNDOWN) st = ST_PHASE;
        else if (lc_ops == 16'd0) st = ST_NONE;
        else lc_ops = lc_ops - 16'd1;
      end
      FN_BEGIN_RUNDOWN: begin
        if (g == 32'd0) st = ST_BADID;
        else if (lc_phase != PH_ACTIVE) st = ST_PHASE;
        else if (g != lc_cur_gen) st = ST_STALE;
        else begin
          lc_admit = 1'b0;
          lc_phase = PH_RUNDOWN;
        end
      end
      FN_COMPLETE_EXIT: begin
        if (g == 32'd0) st = ST_BADID;
        else if (g != lc_cur_gen) st = ST_STALE;
        else if (lc_phase != PH_RUNDOWN) st = ST_PHASE;
        else if (lc_ops != 16'd0) st = ST_INCOMPLETE;
        else begin
          lc_phase   = PH_STOPPED;
          lc_cur_gen = 32'd0;
          lc_admit   = 1'b0;
        end
      end
      FN_RELEASE_HW: begin
        if (lc_phase != PH_PREPARED && lc_phase != PH_STOPPED) st = ST_PHASE;
        else if (lc_cur_gen != 32'd0 || lc_admit || lc_ops != 16'd0) st = ST_PHASE;
        else lc_phase = PH_RELEASED;
      end
      default: st = ST_PHASE;
    endcase
    return '{st, lc_phase, lc_cur_gen, lc_next_gen, lc_ops, lc_admit};
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_gen();
    case ($urandom_range(0, 19))
      0: return 32'd0;
      1: return $urandom;
      2: return lc_cur_gen + 32'd1;
      3: return GEN_LIMIT;
      default: return lc_cur_gen;
    endcase
  endfunction

  // call and return on a falling edge
  task automatic send_event(input logic [3:0] f, input logic [31:0] g,
                            input bit use_typed = 1'b0, input snapshot_t want = '0);
    int gap;
    snapshot_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= f;
    in_generation_in <= g;
    do @(posedge clk); while (in_stall);
    predicted = apply_event(f, g);
    snapshot_q.push_back(use_typed ? want : predicted);
    n_items++;
    @(negedge clk);
  endtask

  task automatic run_session();
    int guard;
    calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 2) != 0) send_event(FN_INIT, $urandom);
    send_event(FN_CREATED, $urandom);
    send_event(FN_PREPARE, $urandom);
    if ($urandom_range(0, 7) == 0) send_event(FN_RELEASE_HW, $urandom);
    repeat ($urandom_range(1, 3)) begin
      send_event(FN_ENTER_ACTIVE, $urandom);
      repeat ($urandom_range(0, 12))
        send_event($urandom_range(0, 2) != 0 ? FN_ACQUIRE : FN_RELEASE, pick_gen());
      send_event(FN_BEGIN_RUNDOWN, pick_gen());
      if ($urandom_range(0, 2) == 0) send_event(FN_COMPLETE_EXIT, pick_gen());
      if ($urandom_range(0, 3) == 0) send_event(FN_ACQUIRE, pick_gen());
      guard = 0;
      while (lc_ops != 16'd0 && guard < 40) begin
        send_event(FN_RELEASE, pick_gen());
        guard++;
      end
      send_event(FN_COMPLETE_EXIT, pick_gen());
    end
    if ($urandom_range(0, 2) == 0) send_event(FN_RELEASE_HW, pick_gen());
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (calm || $urandom_range(0, 99) < 60) begin
      out_stall  <= 1'b0;
      stall_left = calm ? 0 : $urandom_range(0, 6);
    end else begin
      out_stall  <= 1'b1;
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (snapshot_q.size() == 0) begin
        $error("result with no event outstanding: status %0h", out_status);
        n_errors++;
      end else begin
        head = snapshot_q.pop_front();
        check_field("status", head.status, out_status);
        check_field("phase_out", head.phase, out_phase_out);
        check_field("current_gen_out", head.cur_gen, out_current_gen_out);
        check_field("next_gen_out", head.nxt_gen, out_next_gen_out);
        check_field("outstanding_out", head.ops, out_outstanding_out);
        check_field("admission_out", head.admit, out_admission_out);
      end
    end
  end

  initial begin
    int start;
    clear_lifecycle();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (LIFECYCLE_TABLE[i])
      send_event(LIFECYCLE_TABLE[i].func, LIFECYCLE_TABLE[i].gen,
                 LIFECYCLE_TABLE[i].typed_exp, LIFECYCLE_TABLE[i].want);

    send_event(FN_INIT, 32'd0);

    start = n_items;
    while (n_items - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) send_event(4'($urandom_range(0, 15)), pick_gen());
      end else begin
        run_session();
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (snapshot_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> device_lifecycle_rundown_gate_core.f
hw/rtl/dlrg_pkg.sv
hw/rtl/dlrg_ctrl.sv
hw/rtl/dlrg_datapath.sv
hw/rtl/device_lifecycle_rundown_gate_core.sv
sim/device_lifecycle_rundown_gate_core_tb.sv
